@@ hdl/afbta_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afbta_pkg
// Shared types and codes for the anchor-free box target assigner.
// ----------------------------------------------------------------------------
package afbta_pkg;
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	localparam int CFG_STRIDE    = 0;
	localparam int CFG_REACH_MIN = 1;
	localparam int CFG_REACH_MAX = 2;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] box_left;
		logic [15:0] box_top;
		logic [15:0] box_right;
		logic [15:0] box_bottom;
		logic [7:0]  box_class;
		logic [9:0]  cell_col;
		logic [9:0]  cell_row;
	} req_t;

	typedef struct packed {
		logic        is_positive;
		logic [15:0] dist_left;
		logic [15:0] dist_top;
		logic [15:0] dist_right;
		logic [15:0] dist_bottom;
		logic [15:0] centerness;
		logic [7:0]  class_out;
		logic [5:0]  box_slot;
		logic        status;
	} rsp_t;

	// Request into the centerness unit.
	typedef struct packed {
		logic        start;
		logic [31:0] a;
		logic [31:0] b;
	} ctr_cmd_t;

	typedef struct packed {
		logic        done;
		logic [15:0] value;
	} ctr_sts_t;
endpackage
`default_nettype wire

@@ hdl/afbta_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afbta_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface afbta_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/afbta_ctr.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afbta_ctr
// Centerness: floor(sqrt(floor(10A*2^32/(10B+256)))), one bit per cycle.
// ----------------------------------------------------------------------------
module afbta_ctr import afbta_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ctr_cmd_t cmd,
	output ctr_sts_t      sts
);
	typedef enum logic [1:0] {S_IDLE, S_PREP, S_DIV, S_SQRT} state_t;
	state_t      state_q;
	logic [5:0]  cnt_q;
	logic [36:0] den_q;
	logic [36:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] root_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [37:0] rem_sh;
	logic [15:0] trial;
	logic [31:0] trial_sq;

	assign rem_sh   = {rem_q, 1'b0};
	assign trial    = root_q | (16'd1 << cnt_q[3:0]);
	assign trial_sq = trial * trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sts     <= '0;
			cnt_q   <= '0;
		end else begin
			sts.done <= (state_q == S_SQRT) && (cnt_q == 6'd0);
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						a_q     <= cmd.a;
						b_q     <= cmd.b;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					rem_q   <= ({5'd0, a_q} << 3) + ({5'd0, a_q} << 1);
					den_q   <= ({5'd0, b_q} << 3) + ({5'd0, b_q} << 1) + 37'd256;
					quo_q   <= '0;
					cnt_q   <= 6'd0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= 37'(rem_sh - {1'b0, den_q});
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= rem_sh[36:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					if (cnt_q == 6'd31) begin
						cnt_q   <= 6'd15;
						root_q  <= '0;
						state_q <= S_SQRT;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_SQRT: begin
					if (trial_sq <= quo_q) root_q <= trial;
					if (cnt_q == 6'd0) begin
						sts.value <= (trial_sq <= quo_q) ? trial : root_q;
						state_q   <= S_IDLE;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hdl/anchor_free_box_target_assign.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anchor_free_box_target_assign
// Box store with smallest-area containment search and centerness.
// ----------------------------------------------------------------------------
// channel  direction  payload
// req      in         req_t: opcode, box edges and class, grid cell
// rsp      out        rsp_t: distances, centerness, class, slot, status
// cfg      in         cfg_we / cfg_index / cfg_data
// Clear and append answer without a scan; a query scans the stored boxes
// one by one through the one-read-port box memory. A hit then fetches the
// box, computes the distances and runs the 32-step divider and 16-step
// square root.
// Reset clears the box count and registers; memory contents are not cleared.
// The result waits in an output register; a stalled output holds the block.
// ----------------------------------------------------------------------------
module anchor_free_box_target_assign import afbta_pkg::*; #(
	parameter int MAX_BOXES = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	afbta_if.sink                      req,
	afbta_if.source                    rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CW = $clog2(MAX_BOXES + 1);

	typedef enum logic [2:0] {S_IDLE, S_READ, S_SCAN, S_FETCH, S_CALC, S_WAIT, S_OUT}
		state_t;

	logic [71:0] mem [MAX_BOXES];
	logic [71:0] rd_q;
	logic [AW-1:0] rd_addr;

	logic [8:0]  stride_q;
	logic [15:0] rmin_q, rmax_q;
	logic [CW-1:0] count_q;
	state_t      state_q;
	req_t        r_q;
	logic [23:0] px_q, py_q;
	logic [CW-1:0] idx_q;
	logic [AW-1:0] cur_s1;
	logic        vld_s1;
	logic        found_q;
	logic [AW-1:0] best_q;
	logic [31:0] barea_q;
	ctr_cmd_t    ccmd;
	ctr_sts_t    csts;
	logic [15:0] dl_q, dt_q, dr_q, db_q;

	// point coordinate: cell*stride*16 + stride*8
	logic [19:0] colm, rowm;
	assign colm = r_q.cell_col * stride_q;
	assign rowm = r_q.cell_row * stride_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= 9'd8;
			rmin_q   <= '0;
			rmax_q   <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_W'(CFG_STRIDE):    stride_q <= cfg_data[8:0];
				CFG_IDX_W'(CFG_REACH_MIN): rmin_q   <= cfg_data;
				CFG_IDX_W'(CFG_REACH_MAX): rmax_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// box memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (req.valid && req.ready && req.data.opcode == OP_APPEND
			&& count_q < CW'(MAX_BOXES))
			mem[count_q[AW-1:0]] <= {req.data.box_left, req.data.box_top,
				req.data.box_right, req.data.box_bottom, req.data.box_class};
		rd_q <= mem[rd_addr];
	end
	assign rd_addr = (state_q == S_FETCH) ? best_q : idx_q[AW-1:0];

	logic [15:0] x0, y0, x1, y1;
	assign {x0, y0, x1, y1} = rd_q[71:8];

	// test of the box under the scan
	logic inside_b;
	logic [23:0] edl, edt, edr, edb;
	logic [15:0] mx;
	logic [31:0] area;
	assign inside_b = px_q >= {8'd0, x0} && px_q <= {8'd0, x1}
		&& py_q >= {8'd0, y0} && py_q <= {8'd0, y1};
	assign edl = px_q - {8'd0, x0};
	assign edt = py_q - {8'd0, y0};
	assign edr = {8'd0, x1} - px_q;
	assign edb = {8'd0, y1} - py_q;
	always_comb begin
		mx = edl[15:0];
		if (edt[15:0] > mx) mx = edt[15:0];
		if (edr[15:0] > mx) mx = edr[15:0];
		if (edb[15:0] > mx) mx = edb[15:0];
	end
	assign area = (x1 - x0) * (y1 - y0);
	logic qual;
	assign qual = vld_s1 && inside_b && mx >= rmin_q && mx <= rmax_q;

	logic [15:0] mnlr, mnt, mxlr, mxt;
	assign mnlr = (dl_q < dr_q) ? dl_q : dr_q;
	assign mxlr = (dl_q < dr_q) ? dr_q : dl_q;
	assign mnt  = (dt_q < db_q) ? dt_q : db_q;
	assign mxt  = (dt_q < db_q) ? db_q : dt_q;

	afbta_ctr u_ctr (.clk(clk), .arst_n(arst_n), .cmd(ccmd), .sts(csts));

	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rsp.valid <= 1'b0;
			vld_s1    <= 1'b0;
			found_q   <= 1'b0;
			ccmd      <= '0;
			idx_q     <= '0;
		end else begin
			ccmd.start <= (state_q == S_WAIT) && !vld_s1;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						r_q      <= req.data;
						// The status bit flags an append that finds the store full.
						rsp.data <= {{($bits(rsp_t) - 1){1'b0}},
							(req.data.opcode == OP_APPEND) && (count_q >= CW'(MAX_BOXES))};
						idx_q    <= '0;
						found_q  <= 1'b0;
						vld_s1   <= 1'b0;
						case (req.data.opcode)
							OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_OUT;
							end
							OP_APPEND: begin
								if (count_q < CW'(MAX_BOXES)) count_q <= count_q + 1'b1;
								state_q <= S_OUT;
							end
							OP_QUERY: state_q <= S_READ;
							default:  state_q <= S_OUT;
						endcase
						if (req.data.opcode != OP_QUERY) rsp.valid <= 1'b1;
					end
				end
				S_READ: begin
					px_q    <= {colm, 4'd0} + {12'd0, stride_q, 3'd0};
					py_q    <= {rowm, 4'd0} + {12'd0, stride_q, 3'd0};
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// rd_q holds entry cur_s1 when vld_s1 is high
					if (qual && (!found_q || area < barea_q)) begin
						found_q <= 1'b1;
						best_q  <= cur_s1;
						barea_q <= area;
					end
					if (idx_q < count_q) begin
						vld_s1 <= 1'b1;
						cur_s1 <= idx_q[AW-1:0];
						idx_q  <= idx_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							if (found_q) state_q <= S_FETCH;
							else begin
								rsp.valid <= 1'b1;
								state_q   <= S_OUT;
							end
						end
					end
				end
				S_FETCH: state_q <= S_CALC;
				S_CALC: begin
					dl_q <= edl[15:0];
					dt_q <= edt[15:0];
					dr_q <= edr[15:0];
					db_q <= edb[15:0];
					rsp.data.class_out <= rd_q[7:0];
					rsp.data.box_slot  <= 6'(best_q);
					state_q <= S_WAIT;
					vld_s1  <= 1'b0;
				end
				S_WAIT: begin
					if (!vld_s1) begin
						ccmd.a     <= mnlr * mnt;
						ccmd.b     <= mxlr * mxt;
						vld_s1     <= 1'b1;
					end else if (csts.done) begin
						rsp.data.is_positive <= 1'b1;
						rsp.data.dist_left   <= dl_q;
						rsp.data.dist_top    <= dt_q;
						rsp.data.dist_right  <= dr_q;
						rsp.data.dist_bottom <= db_q;
						rsp.data.centerness  <= csts.value;
						rsp.valid <= 1'b1;
						vld_s1    <= 1'b0;
						state_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (rsp.ready) begin
						rsp.valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
